@@ rtl/rle8_bitmap_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// RLE8 decoder assertion macros
// Concurrent assertion wrappers for the checks in the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef RLE8_BITMAP_DECODER_CORE_ASSERT_SVH
`define RLE8_BITMAP_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define RLE8_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rle8 decoder check failed");

// Next-cycle implication, disabled while reset is high
`define RLE8_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rle8 decoder check failed");

`endif

@@ rtl/rle8_pkg.sv @@
// ----------------------------------------------------------------------------
// RLE8 decoder package
// Widths, reset values, register indexes and the result item type.
// ----------------------------------------------------------------------------
package rle8_pkg;

   // Field and state widths
   localparam int DIM_W    = 13;   // cursor and dimension registers
   localparam int COORD_W  = 12;   // span_x / span_y on the result
   localparam int BYTE_W   = 8;

   // Defaults
   localparam int MAX_DIMENSION_DEFAULT = 4096;
   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 13'd256;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // One result item
   typedef struct packed {
      logic [COORD_W-1:0] span_x;
      logic [COORD_W-1:0] span_y;
      logic [BYTE_W-1:0]  span_length;
      logic [BYTE_W-1:0]  pixel_index;
      logic               end_of_bitmap;
   } span_item_type;

   // Result of processing one input item
   typedef struct packed {
      logic          valid;
      span_item_type item;
   } span_result_type;

endpackage

@@ rtl/rle8_if.sv @@
// ----------------------------------------------------------------------------
// RLE8 decoder channel interfaces
// Valid/ready channels for compressed bytes in and span writes out.
// ----------------------------------------------------------------------------
interface rle8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       last_byte;

   modport source (output valid, output stream_byte, output last_byte, input ready);
   modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

interface rle8_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] span_x;
   logic [11:0] span_y;
   logic [7:0]  span_length;
   logic [7:0]  pixel_index;
   logic        end_of_bitmap;

   modport source (output valid, output span_x, output span_y, output span_length,
                   output pixel_index, output end_of_bitmap, input ready);
   modport sink   (input valid, input span_x, input span_y, input span_length,
                   input pixel_index, input end_of_bitmap, output ready);
endinterface

@@ rtl/rle8_bitmap_decoder_core.sv @@
// RLE8 bitmap decoder. Takes one compressed byte per cycle on req_chan and
// gives span writes (x, y, length, palette index, clipped to the configured
// image size) on rsp_chan; the end-of-bitmap escape gives one item with
// end_of_bitmap set and all other fields zero. A byte is held in the input
// register and decoded into the result register at the next edge at which
// that register is free. A span thus passes through the input register and
// the result register before it is valid on rsp_chan. A new byte can be
// taken every cycle while the result channel keeps up. While an undelivered
// span fills the result register, the byte in the input register waits and
// req_chan stalls, even for a byte that gives no span. Image width and height
// are written through the csr_ port; the user must do so only while the block
// is idle, which the block does not enforce. Both are limited to MAX_DIMENSION.
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder top level
// Configuration registers, input register and handshake around the parser.
// ----------------------------------------------------------------------------
module rle8_bitmap_decoder_core
   import rle8_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   rle8_req_if.sink               req_chan,
   rle8_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data
);

   localparam logic [DIM_W:0] MAX_DIM_C = (DIM_W+1)'(MAX_DIMENSION);

   logic [DIM_W-1:0]  image_width_ff;
   logic [DIM_W-1:0]  image_height_ff;
   logic [DIM_W-1:0]  eff_width;
   logic [DIM_W-1:0]  eff_height;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              advance;
   logic              out_free;
   span_result_type   result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_DIM_RESET;
         image_height_ff <= IMAGE_DIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Dimensions limited to the build maximum
   assign eff_width  = ({1'b0, image_width_ff} > MAX_DIM_C) ?
                       MAX_DIM_C[DIM_W-1:0] : image_width_ff;
   assign eff_height = ({1'b0, image_height_ff} > MAX_DIM_C) ?
                       MAX_DIM_C[DIM_W-1:0] : image_height_ff;

   // Input register: decoded when the result register can take its item
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.stream_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   rle8_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (advance),
      .stream_byte (in_byte_ff),
      .last_byte   (in_last_ff),
      .eff_width   (eff_width),
      .eff_height  (eff_height),
      .result      (result)
   );

   rle8_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (result.valid),
      .load_item (result.item),
      .free      (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ rtl/rle8_parser.sv @@
// ----------------------------------------------------------------------------
// RLE8 stream parser
// Holds the parse phase, cursor and counts; turns one byte into at most one
// result item: a clipped span write or the end-of-bitmap marker.
// ----------------------------------------------------------------------------
module rle8_parser
   import rle8_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [BYTE_W-1:0]     stream_byte,
   input  logic                  last_byte,
   input  logic [DIM_W-1:0]      eff_width,
   input  logic [DIM_W-1:0]      eff_height,
   output span_result_type       result
);

`include "rle8_bitmap_decoder_core_assert.svh"

   // Parse phases
   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_DELTA_X = 3'd2;
   localparam logic [2:0] PH_DELTA_Y = 3'd3;
   localparam logic [2:0] PH_LITERAL = 3'd4;
   localparam logic [2:0] PH_PAD     = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;

   // Escape codes in the second byte of a zero-count pair
   localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
   localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
   localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

   localparam logic [DIM_W-1:0] CURSOR_MAX = {DIM_W{1'b1}};

   logic [2:0]        phase_ff, phase_in;
   logic [DIM_W-1:0]  cursor_x_ff, cursor_x_in;
   logic [DIM_W-1:0]  cursor_y_ff, cursor_y_in;
   logic [BYTE_W-1:0] run_count_ff, run_count_in;
   logic [BYTE_W-1:0] literals_left_ff, literals_left_in;
   logic              pad_pending_ff, pad_pending_in;

   logic [BYTE_W-1:0] span_len;
   logic [DIM_W-1:0]  room;
   logic              span_hit;
   logic [BYTE_W-1:0] span_clipped;
   logic              emit_span;
   logic              emit_end;
   logic [BYTE_W-1:0] literals_dec;

   // Saturating cursor add
   function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0]  a,
                                                input logic [BYTE_W-1:0] b);
      logic [DIM_W:0] s;
      s = {1'b0, a} + {{(DIM_W+1-BYTE_W){1'b0}}, b};
      return s[DIM_W] ? CURSOR_MAX : s[DIM_W-1:0];
   endfunction

   // Span at the cursor: a run, or a single literal pixel
   assign span_len     = (phase_ff == PH_LITERAL) ? 8'd1 : run_count_ff;
   assign room         = eff_width - cursor_x_ff;
   assign span_hit     = (span_len != '0) && (cursor_y_ff < eff_height) &&
                         (cursor_x_ff < eff_width);
   assign span_clipped = ({{(DIM_W-BYTE_W){1'b0}}, span_len} > room) ?
                         room[BYTE_W-1:0] : span_len;
   assign literals_dec = (literals_left_ff != '0) ? literals_left_ff - 8'd1 : '0;

   // Next state and result
   always_comb begin
      phase_in         = phase_ff;
      cursor_x_in      = cursor_x_ff;
      cursor_y_in      = cursor_y_ff;
      run_count_in     = run_count_ff;
      literals_left_in = literals_left_ff;
      pad_pending_in   = pad_pending_ff;
      emit_span        = 1'b0;
      emit_end         = 1'b0;

      unique case (phase_ff)
         PH_COUNT: begin
            run_count_in = stream_byte;
            phase_in     = PH_SECOND;
         end
         PH_SECOND: begin
            run_count_in = '0;
            if (run_count_ff != '0) begin
               emit_span   = span_hit;
               cursor_x_in = sat_add(cursor_x_ff, run_count_ff);
               phase_in    = PH_COUNT;
            end else if (stream_byte == ESC_EOL) begin
               cursor_x_in = '0;
               cursor_y_in = sat_add(cursor_y_ff, 8'd1);
               phase_in    = PH_COUNT;
            end else if (stream_byte == ESC_EOB) begin
               emit_end = 1'b1;
               phase_in = PH_DONE;
            end else if (stream_byte == ESC_DELTA) begin
               phase_in = PH_DELTA_X;
            end else begin
               literals_left_in = stream_byte;
               pad_pending_in   = stream_byte[0];
               phase_in         = PH_LITERAL;
            end
         end
         PH_DELTA_X: begin
            cursor_x_in = sat_add(cursor_x_ff, stream_byte);
            phase_in    = PH_DELTA_Y;
         end
         PH_DELTA_Y: begin
            cursor_y_in = sat_add(cursor_y_ff, stream_byte);
            phase_in    = PH_COUNT;
         end
         PH_LITERAL: begin
            emit_span        = span_hit;
            cursor_x_in      = sat_add(cursor_x_ff, 8'd1);
            literals_left_in = literals_dec;
            if (literals_dec == '0) begin
               phase_in = pad_pending_ff ? PH_PAD : PH_COUNT;
            end
         end
         PH_PAD: begin
            pad_pending_in = 1'b0;
            phase_in       = PH_COUNT;
         end
         default: begin
            // end of bitmap seen: bytes are dropped until the stream ends
         end
      endcase

      // last byte rearms the parser
      if (last_byte) begin
         phase_in         = PH_COUNT;
         cursor_x_in      = '0;
         cursor_y_in      = '0;
         run_count_in     = '0;
         literals_left_in = '0;
         pad_pending_in   = 1'b0;
      end
   end

   // Result item; the end marker carries all-zero span fields
   always_comb begin
      result.valid              = item_valid && (emit_span || emit_end);
      result.item.span_x        = emit_end ? '0 : cursor_x_ff[COORD_W-1:0];
      result.item.span_y        = emit_end ? '0 : cursor_y_ff[COORD_W-1:0];
      result.item.span_length   = emit_end ? '0 : span_clipped;
      result.item.pixel_index   = emit_end ? '0 : stream_byte;
      result.item.end_of_bitmap = emit_end;
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_COUNT;
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         run_count_ff     <= '0;
         literals_left_ff <= '0;
         pad_pending_ff   <= 1'b0;
      end else if (item_valid) begin
         phase_ff         <= phase_in;
         cursor_x_ff      <= cursor_x_in;
         cursor_y_ff      <= cursor_y_in;
         run_count_ff     <= run_count_in;
         literals_left_ff <= literals_left_in;
         pad_pending_ff   <= pad_pending_in;
      end
   end

   // Checks
   `RLE8_ASSERT_SAME(a_done_silent, clock, reset,
      item_valid && (phase_ff == PH_DONE), !result.valid)
   `RLE8_ASSERT_SAME(a_span_nonzero, clock, reset,
      result.valid && !result.item.end_of_bitmap, result.item.span_length != '0)
   `RLE8_ASSERT_NEXT(a_last_rearms, clock, reset,
      item_valid && last_byte,
      (phase_ff == PH_COUNT) && (cursor_x_ff == '0) && (cursor_y_ff == '0))
   `RLE8_ASSERT_NEXT(a_literal_tail, clock, reset,
      item_valid && !last_byte && (phase_ff == PH_LITERAL) &&
      (literals_left_ff == 8'd1) && !pad_pending_ff,
      phase_ff == PH_COUNT)

endmodule

@@ rtl/rle8_out_stage.sv @@
// ----------------------------------------------------------------------------
// RLE8 result register
// Holds one span item for the result channel and frees itself as it is taken.
// ----------------------------------------------------------------------------
module rle8_out_stage
   import rle8_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  span_item_type   load_item,
   output logic            free,
   rle8_rsp_if.source      rsp_chan
);

   logic          valid_ff;
   logic          valid_in;
   span_item_type item_ff;

   // Slot can take a new item when empty or when the held item leaves now
   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.span_x        = item_ff.span_x;
   assign rsp_chan.span_y        = item_ff.span_y;
   assign rsp_chan.span_length   = item_ff.span_length;
   assign rsp_chan.pixel_index   = item_ff.pixel_index;
   assign rsp_chan.end_of_bitmap = item_ff.end_of_bitmap;

endmodule

@@ tb/sv/rle8_stream_pkg.sv @@
// ----------------------------------------------------------------------------
// RLE8 stream codes for verification
// Escape codes of the compressed stream and the cursor ceiling, shared by the
// stimulus generator and the span checker.
// ----------------------------------------------------------------------------
package rle8_stream_pkg;

   // Count byte of zero introduces an escape or a literal group
   localparam logic [7:0] ESC_MARK          = 8'd0;

   // Second byte after ESC_MARK
   localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
   localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
   localparam logic [7:0] ESC_DELTA         = 8'd2;

   // Cursor saturates here
   localparam int unsigned CURSOR_LIMIT = 8191;

endpackage

@@ tb/sv/rle8_span_checker.sv @@
// ----------------------------------------------------------------------------
// RLE8 span checker
// Watches the byte, span and register ports of the decoder, decodes every
// accepted byte with its own parser copy and compares each accepted span
// item field by field against the oldest predicted span.
// ----------------------------------------------------------------------------
module rle8_span_checker
   import rle8_pkg::*;
   import rle8_stream_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rle8_req_if                    req_mon,
   rle8_rsp_if                    rsp_mon,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data,
   output int                     fail_count,
   output int                     pending_count
);

   typedef enum logic [2:0] {
      AWAIT_COUNT,
      AWAIT_VALUE,
      AWAIT_DX,
      AWAIT_DY,
      LITERAL_RUN,
      AWAIT_PAD,
      STREAM_DONE
   } parse_phase_type;

   // Parser copy
   parse_phase_type  phase;
   logic [DIM_W-1:0] cursor_x;
   logic [DIM_W-1:0] cursor_y;
   logic [7:0]       held_count;
   logic [7:0]       literals_left;
   logic             pad_pending;

   // Register copy
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;

   span_item_type    predicted_spans[$];
   int               mismatches = 0;

   function automatic logic [DIM_W-1:0] step_cursor(logic [DIM_W-1:0] pos,
                                                    int unsigned add);
      int unsigned sum;
      sum = pos + add;
      return (sum > CURSOR_LIMIT) ? DIM_W'(CURSOR_LIMIT) : DIM_W'(sum);
   endfunction

   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] dim);
      return (dim > MAX_DIMENSION_DEFAULT) ? MAX_DIMENSION_DEFAULT : dim;
   endfunction

   function automatic void clear_parser();
      phase         = AWAIT_COUNT;
      cursor_x      = '0;
      cursor_y      = '0;
      held_count    = '0;
      literals_left = '0;
      pad_pending   = 1'b0;
   endfunction

   // Span at the cursor, clipped at the right edge; 0 when empty or wholly off image
   function automatic bit clip_span(int unsigned len, logic [7:0] idx,
                                    output span_item_type span);
      int unsigned w;
      int unsigned h;
      w    = clamp_dim(width_reg);
      h    = clamp_dim(height_reg);
      span = '0;
      if (len == 0 || cursor_y >= h || cursor_x >= w) return 1'b0;
      if (len > w - cursor_x) len = w - cursor_x;
      span.span_x      = cursor_x[COORD_W-1:0];
      span.span_y      = cursor_y[COORD_W-1:0];
      span.span_length = 8'(len);
      span.pixel_index = idx;
      return 1'b1;
   endfunction

   // Advance the parser by one byte; returns 1 when a span item results
   function automatic bit decode_byte(logic [7:0] value, logic last,
                                      output span_item_type span);
      bit produced;
      produced = 1'b0;
      span     = '0;
      case (phase)
         AWAIT_COUNT: begin
            held_count = value;
            phase      = AWAIT_VALUE;
         end
         AWAIT_VALUE: begin
            if (held_count != 0) begin
               produced = clip_span(held_count, value, span);
               cursor_x = step_cursor(cursor_x, held_count);
               phase    = AWAIT_COUNT;
            end else begin
               case (value)
                  ESC_END_OF_LINE: begin
                     cursor_x = '0;
                     cursor_y = step_cursor(cursor_y, 1);
                     phase    = AWAIT_COUNT;
                  end
                  ESC_END_OF_BITMAP: begin
                     span.end_of_bitmap = 1'b1;
                     produced           = 1'b1;
                     phase              = STREAM_DONE;
                  end
                  ESC_DELTA: begin
                     phase = AWAIT_DX;
                  end
                  default: begin
                     literals_left = value;
                     pad_pending   = value[0];
                     phase         = LITERAL_RUN;
                  end
               endcase
            end
            held_count = '0;
         end
         AWAIT_DX: begin
            cursor_x = step_cursor(cursor_x, value);
            phase    = AWAIT_DY;
         end
         AWAIT_DY: begin
            cursor_y = step_cursor(cursor_y, value);
            phase    = AWAIT_COUNT;
         end
         LITERAL_RUN: begin
            produced = clip_span(1, value, span);
            cursor_x = step_cursor(cursor_x, 1);
            if (literals_left != 0) literals_left = literals_left - 1;
            if (literals_left == 0) phase = pad_pending ? AWAIT_PAD : AWAIT_COUNT;
         end
         AWAIT_PAD: begin
            pad_pending = 1'b0;
            phase       = AWAIT_COUNT;
         end
         default: begin
            // end of bitmap seen: bytes are dropped until the stream ends
         end
      endcase
      if (last) clear_parser();
      return produced;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Register writes, span compare, then prediction of the new byte
   always @(posedge clock) begin : monitor
      span_item_type want;
      span_item_type made;
      if (reset) begin
         width_reg  = IMAGE_DIM_RESET;
         height_reg = IMAGE_DIM_RESET;
         clear_parser();
         predicted_spans.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_write_data;
               CSR_IMAGE_HEIGHT: height_reg = csr_write_data;
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_spans.size() == 0) begin
               $error("span item with no prediction waiting: x %0d y %0d len %0d",
                      rsp_mon.span_x, rsp_mon.span_y, rsp_mon.span_length);
               mismatches++;
            end else begin
               want = predicted_spans.pop_front();
               check_field("span_x", want.span_x, rsp_mon.span_x);
               check_field("span_y", want.span_y, rsp_mon.span_y);
               check_field("span_length", want.span_length, rsp_mon.span_length);
               check_field("pixel_index", want.pixel_index, rsp_mon.pixel_index);
               check_field("end_of_bitmap", want.end_of_bitmap, rsp_mon.end_of_bitmap);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (decode_byte(req_mon.stream_byte, req_mon.last_byte, made))
               predicted_spans.push_back(made);
         end
      end
      pending_count <= predicted_spans.size();
      fail_count    <= mismatches;
   end

endmodule

@@ tb/sv/rle8_bitmap_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder testbench
// Drives compressed streams into the decoder through several image sizes:
// a directed opening, then random well-formed streams with noise, cut-off
// endings and cursor saturation, under random gaps and result stalls. The
// span checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rle8_bitmap_decoder_core_tb;
   import rle8_pkg::*;
   import rle8_stream_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 155;
   localparam int PHASE_COUNT   = 8;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DIM_W-1:0]       csr_write_data;
   int                     fail_count;
   int                     pending_count;

   logic [7:0]             stream_q[$];
   int                     items_sent;
   bit                     req_burst;

   rle8_req_if req_chan();
   rle8_rsp_if rsp_chan();

   rle8_bitmap_decoder_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rle8_span_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // One byte item, after a random gap unless in a burst
   task automatic send_byte(logic [7:0] value, logic last);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.stream_byte <= value;
      req_chan.last_byte   <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stop sending, wait for every predicted span, then let the pipe settle
   task automatic drain_and_settle(int settle);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic program_image_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index        <= CSR_IMAGE_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Runs past the right edge, then deltas until both cursors pin at the ceiling
   task automatic add_saturation();
      repeat (33) begin
         stream_q.push_back(8'hFF);
         stream_q.push_back(8'($urandom));
      end
      repeat (34) begin
         stream_q.push_back(ESC_MARK);
         stream_q.push_back(ESC_DELTA);
         stream_q.push_back(8'hFF);
         stream_q.push_back(8'hFF);
      end
      stream_q.push_back(ESC_MARK);
      stream_q.push_back(ESC_END_OF_LINE);
      stream_q.push_back(8'h10);
      stream_q.push_back(8'($urandom));
   endtask

   // One random command: mostly runs and literal groups
   task automatic add_command();
      int kind;
      int n;
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
         stream_q.push_back(8'(n));
         stream_q.push_back(8'($urandom));
      end else if (kind < 11) begin
         stream_q.push_back(ESC_MARK);
         stream_q.push_back(ESC_END_OF_LINE);
      end else if (kind < 13) begin
         stream_q.push_back(ESC_MARK);
         stream_q.push_back(ESC_DELTA);
         repeat (2) begin
            n = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255);
            stream_q.push_back(8'(n));
         end
      end else if (kind < 19) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
         stream_q.push_back(ESC_MARK);
         stream_q.push_back(8'(n));
         repeat (n) stream_q.push_back(8'($urandom));
         // odd groups carry a pad byte
         if (n % 2 == 1) stream_q.push_back(8'($urandom));
      end else begin
         stream_q.push_back(8'($urandom));
      end
   endtask

   // Build one stream, send it with the last flag on its final byte
   task automatic send_stream();
      int cmds;
      int junk;
      stream_q.delete();
      junk = 0;
      if ($urandom_range(0, 29) == 0) add_saturation();
      cmds = $urandom_range(1, 12);
      repeat (cmds) add_command();
      if ($urandom_range(0, 1)) begin
         stream_q.push_back(ESC_MARK);
         stream_q.push_back(ESC_END_OF_BITMAP);
         junk = $urandom_range(0, 3);
         repeat (junk) stream_q.push_back(8'($urandom));
      end else if ($urandom_range(0, 5) == 0 && stream_q.size() > 3) begin
         // cut the stream mid-command
         repeat ($urandom_range(1, 3)) void'(stream_q.pop_back());
      end
      req_burst = ($urandom_range(0, 3) == 0);
      foreach (stream_q[i]) send_byte(stream_q[i], 1'(i == stream_q.size() - 1));
      items_sent += stream_q.size() - junk;
   endtask

   // Result side: random stall per item, with stall-free stretches
   initial begin : span_drain
      int stall;
      bit burst;
      stall = 0;
      burst = 1'b0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         if ($urandom_range(0, 15) == 0) burst = !burst;
         stall = burst ? 0 : $urandom_range(0, 13);
      end
   end

   // Watchdog on cycles without any handshake or register write
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("rle8_bitmap_decoder_core regression: fail");
      $finish;
   end

   // Stimulus and verdict
   initial begin : stimulus
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.stream_byte <= '0;
      req_chan.last_byte   <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_IMAGE_WIDTH;
      csr_write_data       <= '0;
      req_burst            = 1'b0;
      items_sent           = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset image size of 256 x 256
      send_byte(8'hFF, 1'b0);            // full-length run from the origin
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);            // single pixel on the last column
      send_byte(8'hFF, 1'b0);
      send_byte(8'h05, 1'b0);            // starts past the right edge: dropped
      send_byte(8'hAA, 1'b0);
      send_byte(ESC_MARK, 1'b0);         // end of line
      send_byte(ESC_END_OF_LINE, 1'b0);
      send_byte(ESC_MARK, 1'b0);         // delta move
      send_byte(ESC_DELTA, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(ESC_MARK, 1'b0);         // odd literal group plus pad
      send_byte(8'h03, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(ESC_MARK, 1'b0);         // end of bitmap, then an ignored byte
      send_byte(ESC_END_OF_BITMAP, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'h07, 1'b1);            // pair cut off by the last byte
      send_byte(ESC_MARK, 1'b0);         // delta cut off after dx
      send_byte(ESC_DELTA, 1'b0);
      send_byte(8'h09, 1'b1);
      drain_and_settle(SETTLE_CYCLES);

      // Random streams over a sweep of image sizes
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       begin w = 13'd1;    h = 13'd1;    end
            1:       begin w = 13'd4096; h = 13'd4096; end
            2:       begin w = 13'd8191; h = 13'd8191; end
            3:       begin w = 13'd0;    h = 13'd37;   end
            4:       begin w = 13'd50;   h = 13'd0;    end
            5:       begin
               w = DIM_W'($urandom_range(1, 4096));
               h = DIM_W'($urandom_range(1, 64));
            end
            6:       begin w = 13'd300;  h = 13'd5;    end
            default: begin w = 13'd64;   h = 13'd64;   end
         endcase
         program_image_size(w, h);
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) send_stream();
         drain_and_settle(SETTLE_CYCLES);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("rle8_bitmap_decoder_core regression: pass");
      else
         $display("rle8_bitmap_decoder_core regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rle8_pkg.sv
rtl/rle8_if.sv
rtl/rle8_parser.sv
rtl/rle8_out_stage.sv
rtl/rle8_bitmap_decoder_core.sv
tb/sv/rle8_stream_pkg.sv
tb/sv/rle8_span_checker.sv
tb/sv/rle8_bitmap_decoder_core_tb.sv
